FILE: rtl/core/hash_coordinate_jitter_core_assert.svh
// Assertion macros shared by the hash coordinate jitter RTL.
`ifndef HASH_COORDINATE_JITTER_CORE_ASSERT_SVH
`define HASH_COORDINATE_JITTER_CORE_ASSERT_SVH

`ifndef ASSERT_OFF
// Clocked assertion that is switched off while reset is high.
`define HCJ_ASSERT(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// Clocked assertion that is also checked during reset.
`define HCJ_ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define HCJ_ASSERT(label, clock, reset, prop, msg)
`define HCJ_ASSERT_ALWAYS(label, clock, prop, msg)
`endif

`endif

FILE: rtl/core/hcj_pkg.sv
// Shared widths, constants and register codes of the hash coordinate jitter block.
package hcj_pkg;

  localparam int unsigned PIXEL_W      = 32;
  localparam int unsigned COORD_W      = 8;
  localparam int unsigned SIZE_W       = 9;
  localparam int unsigned AMT_W        = 16;
  localparam int unsigned CFG_DATA_W   = 16;
  localparam int unsigned MAX_EXEMPLAR = 256;

  localparam logic [PIXEL_W-1:0] MIX_MULT = 32'h045d9f3b;

  typedef enum logic [0:0] {
    REG_EXEMPLAR_SIZE = 1'b0,
    REG_JITTER_AMOUNT = 1'b1
  } cfg_reg_t;

endpackage

FILE: rtl/core/hcj_pixel_if.sv
// Input channel carrying one pixel index and its exemplar coordinate pair.
interface hcj_pixel_if;
  import hcj_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_index;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;

  modport source (output valid, output pixel_index, output coord_x, output coord_y,
                  input ready);
  modport sink (input valid, input pixel_index, input coord_x, input coord_y,
                output ready);
endinterface

FILE: rtl/core/hcj_result_if.sv
// Output channel carrying one jittered exemplar coordinate pair.
interface hcj_result_if;
  import hcj_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] jittered_x;
  logic [COORD_W-1:0] jittered_y;

  modport source (output valid, output jittered_x, output jittered_y, input ready);
  modport sink (input valid, input jittered_x, input jittered_y, output ready);
endinterface

FILE: rtl/core/hash_coordinate_jitter_core.sv
// Hash coordinate jitter: one pixel a cycle in while the result side accepts. The
// index is mixed twice by a 32-bit multiply hash (four multiplier stages), the low nine
// bits of each hash scale the jitter amount in a signed multiplier, and the rounded offset
// is added to the coordinate and wrapped into 0 .. size-1 by a two-stage restoring
// reduction. Every stage holds its own valid bit and moves up when the stage after it is
// empty or moving, so bubbles close up and the block takes a new transaction each cycle
// the result side accepts. Size 0 acts as 1, size above 256 as 256, and the jitter amount
// saturates at size times 256. Configuration takes effect on pixels accepted afterwards
// and must be written only with the pipeline empty.
module hash_coordinate_jitter_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  hcj_pkg::cfg_reg_t cfg_index,
  input  logic [hcj_pkg::CFG_DATA_W-1:0] cfg_data,
  hcj_pixel_if.sink         pixel,
  hcj_result_if.source      result
);
  import hcj_pkg::*;

  `include "hash_coordinate_jitter_core_assert.svh"

  localparam int unsigned STAGES = 9;
  localparam int unsigned WRAP_W = 10;
  localparam int unsigned BOUND_W = SIZE_W + 8;
  localparam int unsigned PROD_W = BOUND_W + 1 + 10;
  localparam int unsigned OFF_W = 12;

  // ---------------------------------------------------------------- helpers
  function automatic logic [PIXEL_W-1:0] xorshift(input logic [PIXEL_W-1:0] x);
    xorshift = (x >> 16) ^ x;
  endfunction

  function automatic logic [PIXEL_W-1:0] mixmul(input logic [PIXEL_W-1:0] x);
    mixmul = xorshift(x) * MIX_MULT;
  endfunction

  // Hash bits 0..511 become a signed step -256..255.
  function automatic logic signed [9:0] hash_step(input logic [8:0] h);
    hash_step = $signed({1'b0, h}) - 10'sd256;
  endfunction

  // Jitter amount times the signed step, both widened to the product width first.
  function automatic logic signed [PROD_W-1:0] scale_step(input logic [BOUND_W-1:0] amt,
                                                          input logic [8:0] h);
    logic signed [9:0]        st;
    logic signed [PROD_W-1:0] amt_ext;
    logic signed [PROD_W-1:0] st_ext;
    st         = hash_step(h);
    amt_ext    = $signed({{(PROD_W-BOUND_W){1'b0}}, amt});
    st_ext     = {{(PROD_W-10){st[9]}}, st};
    scale_step = amt_ext * st_ext;
  endfunction

  // Five restoring steps of the reduction modulo m, starting at shift top.
  function automatic logic [WRAP_W-1:0] mod_part(input logic [WRAP_W-1:0] r,
                                                 input logic [SIZE_W-1:0] m,
                                                 input int unsigned top);
    logic [WRAP_W-1:0] rem;
    logic [WRAP_W+SIZE_W-1:0] d;
    rem = r;
    for (int i = 0; i < 5; i++) begin
      d = {{WRAP_W{1'b0}}, m} << (top - i);
      if ({{SIZE_W{1'b0}}, rem} >= d) begin
        rem = rem - d[WRAP_W-1:0];
      end
    end
    mod_part = rem;
  endfunction

  // Rounded offset plus coordinate plus m, which is never negative since |offset| <= m.
  function automatic logic [WRAP_W-1:0] biased_sum(input logic signed [PROD_W-1:0] prod,
                                                   input logic [COORD_W-1:0] c,
                                                   input logic [SIZE_W-1:0] m);
    logic signed [PROD_W-1:0] rnd;
    logic signed [OFF_W-1:0]  off;
    logic signed [OFF_W-1:0]  sum;
    rnd = prod + PROD_W'(32768);
    off = OFF_W'(rnd >>> 16);
    sum = off + $signed({{(OFF_W-COORD_W){1'b0}}, c}) + $signed({{(OFF_W-SIZE_W){1'b0}}, m});
    biased_sum = sum[WRAP_W-1:0];
  endfunction

  // ---------------------------------------------------------------- configuration
  logic [SIZE_W-1:0] exemplar_size;
  logic [AMT_W-1:0]  jitter_amount;

  always_ff @(posedge clk) begin
    if (rst) begin
      exemplar_size <= SIZE_W'(MAX_EXEMPLAR);
      jitter_amount <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_EXEMPLAR_SIZE: exemplar_size <= cfg_data[SIZE_W-1:0];
        REG_JITTER_AMOUNT: jitter_amount <= cfg_data[AMT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [SIZE_W-1:0]  m_eff;
  logic [BOUND_W-1:0] bound;
  logic [BOUND_W-1:0] amt_eff;

  always_comb begin
    if (exemplar_size == '0) begin
      m_eff = SIZE_W'(1);
    end else if (exemplar_size > SIZE_W'(MAX_EXEMPLAR)) begin
      m_eff = SIZE_W'(MAX_EXEMPLAR);
    end else begin
      m_eff = exemplar_size;
    end
    bound   = {m_eff, 8'b0};
    amt_eff = (BOUND_W'(jitter_amount) > bound) ? bound : BOUND_W'(jitter_amount);
  end

  // ---------------------------------------------------------------- flow control
  logic [STAGES-1:0] vld;
  logic [STAGES:0]   adv;

  always_comb begin
    adv[STAGES] = result.ready;
    for (int k = STAGES - 1; k >= 0; k--) begin
      adv[k] = !vld[k] || adv[k+1];
    end
  end

  assign pixel.ready = adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= pixel.valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (adv[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  logic [PIXEL_W-1:0] s1_t, s1_p;
  logic [COORD_W-1:0] s1_x, s1_y;
  logic [PIXEL_W-1:0] s2_t, s2_p;
  logic [COORD_W-1:0] s2_x, s2_y;
  logic [PIXEL_W-1:0] s3_s;
  logic [8:0]         s3_a;
  logic [COORD_W-1:0] s3_x, s3_y;
  logic [PIXEL_W-1:0] s4_u;
  logic signed [PROD_W-1:0] s4_px;
  logic [COORD_W-1:0] s4_x, s4_y;
  logic [PIXEL_W-1:0] s5_u;
  logic [WRAP_W-1:0]  s5_wx;
  logic [COORD_W-1:0] s5_y;
  logic signed [PROD_W-1:0] s6_py;
  logic [WRAP_W-1:0]  s6_rx;
  logic [COORD_W-1:0] s6_y;
  logic [WRAP_W-1:0]  s7_wy;
  logic [COORD_W-1:0] s7_rx;
  logic [WRAP_W-1:0]  s8_ry;
  logic [COORD_W-1:0] s8_rx;
  logic [COORD_W-1:0] s9_rx, s9_ry;

  logic [PIXEL_W-1:0] a_full;
  logic [PIXEL_W-1:0] b_full;
  logic [WRAP_W-1:0]  rx_full;
  logic [WRAP_W-1:0]  ry_full;

  assign a_full  = xorshift(s2_t);
  assign b_full  = xorshift(s5_u);
  assign rx_full = mod_part(s6_rx, m_eff, 4);
  assign ry_full = mod_part(s8_ry, m_eff, 4);

  always_ff @(posedge clk) begin
    // First mix of the index.
    if (adv[0]) begin
      s1_t <= mixmul(pixel.pixel_index);
      s1_p <= pixel.pixel_index;
      s1_x <= pixel.coord_x;
      s1_y <= pixel.coord_y;
    end
    if (adv[1]) begin
      s2_t <= mixmul(s1_t);
      s2_p <= s1_p;
      s2_x <= s1_x;
      s2_y <= s1_y;
    end
    // Hash a is complete; seed of the second hash is a plus the index.
    if (adv[2]) begin
      s3_s <= a_full + s2_p;
      s3_a <= a_full[8:0];
      s3_x <= s2_x;
      s3_y <= s2_y;
    end
    if (adv[3]) begin
      s4_u  <= mixmul(s3_s);
      s4_px <= scale_step(amt_eff, s3_a);
      s4_x  <= s3_x;
      s4_y  <= s3_y;
    end
    if (adv[4]) begin
      s5_u  <= mixmul(s4_u);
      s5_wx <= biased_sum(s4_px, s4_x, m_eff);
      s5_y  <= s4_y;
    end
    if (adv[5]) begin
      s6_py <= scale_step(amt_eff, b_full[8:0]);
      s6_rx <= mod_part(s5_wx, m_eff, 9);
      s6_y  <= s5_y;
    end
    if (adv[6]) begin
      s7_wy <= biased_sum(s6_py, s6_y, m_eff);
      s7_rx <= rx_full[COORD_W-1:0];
    end
    if (adv[7]) begin
      s8_ry <= mod_part(s7_wy, m_eff, 9);
      s8_rx <= s7_rx;
    end
    if (adv[8]) begin
      s9_ry <= ry_full[COORD_W-1:0];
      s9_rx <= s8_rx;
    end
  end

  assign result.valid      = vld[STAGES-1];
  assign result.jittered_x = s9_rx;
  assign result.jittered_y = s9_ry;

  // ---------------------------------------------------------------- assertions
  `HCJ_ASSERT_ALWAYS(a_reset_empties, clk, rst |=> !result.valid, "result valid after reset")
  `HCJ_ASSERT(a_ready_passes, clk, rst, result.ready |-> pixel.ready, "input blocked")
  `HCJ_ASSERT(a_stall_has_room, clk, rst, (pixel.ready && !result.ready) |-> !(&vld), "no room")
  `HCJ_ASSERT(a_accept_enters, clk, rst, (pixel.valid && pixel.ready) |=> vld[0], "entry lost")

endmodule
